// File: sv/pee_pkg.sv
// Package for the postfix expression evaluator: status codes, characters, FSM states.
// No dependencies.
package pee_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'd48;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_MUL,
        S_DIV,
        S_PUSH,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        SOP_HOLD,
        SOP_PUSH,
        SOP_POP,
        SOP_CLEAR
    } stack_op_t;

endpackage

// File: sv/pee_cell.sv
// One stack cell: holds a word and shifts with its neighbours on push and pop.
// Depends on pee_pkg.
module pee_cell
    import pee_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  stack_op_t              op,
    input  logic [VALUE_WIDTH-1:0] above,
    input  logic [VALUE_WIDTH-1:0] below,
    output logic [VALUE_WIDTH-1:0] word
);

    logic [VALUE_WIDTH-1:0] word_reg;
    logic [VALUE_WIDTH-1:0] word_next;

    always_comb
    begin
        case (op)
            SOP_PUSH: word_next = above;
            SOP_POP:  word_next = below;
            default:  word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// File: sv/pee_divider.sv
// Iterative signed divider, one quotient bit a cycle, truncating toward zero.
// Depends on nothing beyond its ports.
module pee_divider #(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [VALUE_WIDTH-1:0] r_reg, r_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic                   neg_reg, neg_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] mag_a, mag_b;

    assign mag_a = dividend[VALUE_WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b = divisor[VALUE_WIDTH-1] ? (~divisor + 1'b1) : divisor;
    assign trial = {r_reg, q_reg[VALUE_WIDTH-1]} - {1'b0, d_reg};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = mag_a;
            r_next    = '0;
            d_next    = mag_b;
            neg_next  = dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
            cnt_next  = CW'(VALUE_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[VALUE_WIDTH])
            begin
                r_next = trial[VALUE_WIDTH-1:0];
                q_next = {q_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[VALUE_WIDTH-2:0], q_reg[VALUE_WIDTH-1]};
                q_next = {q_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

// File: sv/postfix_expression_evaluator_top.sv
// Top level of the postfix expression evaluator: sequencer, cell chain, divider.
// Depends on pee_pkg, pee_cell and pee_divider.
//
// Usage: one request on the input channel carries one character (char_byte) or
// an end mark (end_of_expr). Digits build a decimal number, a space pushes it,
// an operator pops two operands and pushes the result. The operand stack is a
// chain of STACK_DEPTH cells; the top is cell 0 and the whole chain shifts on
// push and pop. An end request pushes any pending number, pops the top and
// emits value and status as one request on the output channel, then clears.
// An operator passes through S_POP twice (for b, then a), then S_MUL for * or
// S_DIV for / by a nonzero divisor, then S_PUSH; digits, spaces and skipped
// characters are handled in S_IDLE alone. A / waits in S_DIV for the divider,
// which yields one quotient bit a cycle. An end request pops the top in S_POP
// and then shows the result in S_OUT. Only one request is processed at a time.
// Reset clears the sequencer, the count, the number and the status; the cells
// hold no reset value. If the receiver stalls, the result is held in the
// output register and no new request is taken until it is accepted.
module postfix_expression_evaluator_top
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    char_byte,
    input  logic                          end_of_expr,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0] value,
    output logic [1:0]                    status
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   pend_reg, pend_next;
    logic                   skip_reg, skip_next;
    status_t                stat_reg, stat_next;
    logic [VALUE_WIDTH-1:0] a_reg, a_next;
    logic [VALUE_WIDTH-1:0] b_reg, b_next;
    logic [VALUE_WIDTH-1:0] r_reg, r_next;
    logic [7:0]             opc_reg, opc_next;
    logic                   fin_reg, fin_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [1:0]             ost_reg, ost_next;
    logic                   ph_reg, ph_next;

    stack_op_t              sop;
    logic [VALUE_WIDTH-1:0] push_word;
    logic [VALUE_WIDTH-1:0] words [STACK_DEPTH];
    logic                   div_start, div_done;
    logic [VALUE_WIDTH-1:0] div_q;
    logic                   accept, is_op, stack_full;
    logic [2*VALUE_WIDTH-1:0] prod;
    status_t                st_tmp;

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] above_w, below_w;
            if (gi == 0)
            begin : g_top
                assign above_w = push_word;
            end
            else
            begin : g_mid
                assign above_w = words[gi-1];
            end
            if (gi == STACK_DEPTH - 1)
            begin : g_bot
                assign below_w = '0;
            end
            else
            begin : g_up
                assign below_w = words[gi+1];
            end
            pee_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
                .clk   (clk),
                .op    (sop),
                .above (above_w),
                .below (below_w),
                .word  (words[gi])
            );
        end
    endgenerate

    pee_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_next),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign is_op      = (char_byte == CH_PLUS) || (char_byte == CH_MINUS)
                     || (char_byte == CH_MUL) || (char_byte == CH_DIV);
    assign stack_full = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign prod       = a_reg * b_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && end_of_expr)
                    state_next = S_POP;
                else if (accept && !skip_reg && !pend_reg && is_op)
                    state_next = S_POP;
            end
            S_POP:
            begin
                if (fin_reg)
                    state_next = S_OUT;
                else if (!ph_reg)
                    state_next = S_POP;
                else if (opc_reg == CH_MUL)
                    state_next = S_MUL;
                else if (opc_reg == CH_DIV && b_reg != '0)
                    state_next = S_DIV;
                else
                    state_next = S_PUSH;
            end
            S_MUL:   state_next = S_PUSH;
            S_DIV:   state_next = div_done ? S_PUSH : S_DIV;
            S_PUSH:  state_next = S_IDLE;
            S_OUT:   state_next = out_ready ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // S_POP runs two pops for an operator (b then a) using the phase in ph_reg
    always_comb
    begin
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        skip_next = skip_reg;
        stat_next = stat_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        opc_next  = opc_reg;
        fin_next  = fin_reg;
        val_next  = val_reg;
        ost_next  = ost_reg;
        ph_next   = ph_reg;
        sop       = SOP_HOLD;
        push_word = acc_reg;
        div_start = 1'b0;
        st_tmp    = stat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (end_of_expr)
                    begin
                        fin_next = 1'b1;
                        ph_next  = 1'b0;
                        if (pend_reg)
                        begin
                            if (stack_full)
                            begin
                                if (stat_reg == ST_OK)
                                    stat_next = ST_OVER;
                            end
                            else
                            begin
                                sop      = SOP_PUSH;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                    end
                    else if (skip_reg)
                        skip_next = 1'b0;
                    else if (char_byte == CH_SPACE)
                    begin
                        if (pend_reg)
                        begin
                            if (stack_full)
                            begin
                                if (stat_reg == ST_OK)
                                    stat_next = ST_OVER;
                            end
                            else
                            begin
                                sop      = SOP_PUSH;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            acc_next  = '0;
                            pend_next = 1'b0;
                        end
                    end
                    else if (!pend_reg && is_op)
                    begin
                        fin_next = 1'b0;
                        ph_next  = 1'b0;
                        opc_next = char_byte;
                    end
                    else
                    begin
                        acc_next  = acc_reg * VALUE_WIDTH'(10)
                                  + VALUE_WIDTH'(char_byte) - VALUE_WIDTH'(CH_ZERO);
                        pend_next = 1'b1;
                    end
                end
            end
            S_POP:
            begin
                if (cnt_reg == '0)
                begin
                    if (stat_reg == ST_OK)
                        st_tmp = ST_UNDER;
                    stat_next = st_tmp;
                    r_next    = '0;
                end
                else
                begin
                    sop      = SOP_POP;
                    cnt_next = cnt_reg - 1'b1;
                    r_next   = words[0];
                end
                if (fin_reg)
                begin
                    val_next  = (cnt_reg == '0) ? '0 : words[0];
                    ost_next  = st_tmp;
                    cnt_next  = '0;
                    acc_next  = '0;
                    pend_next = 1'b0;
                    skip_next = 1'b0;
                    stat_next = ST_OK;
                end
                else if (!ph_reg)
                begin
                    b_next  = r_next;
                    ph_next = 1'b1;
                end
                else
                begin
                    a_next  = r_next;
                    ph_next = 1'b0;
                end
            end
            S_MUL:
                r_next = prod[VALUE_WIDTH-1:0];
            S_DIV:
            begin
                if (div_done)
                    r_next = div_q;
            end
            S_PUSH:
            begin
                push_word = r_reg;
                skip_next = 1'b1;
                if (stack_full)
                begin
                    if (stat_reg == ST_OK)
                        stat_next = ST_OVER;
                end
                else
                begin
                    sop      = SOP_PUSH;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: ;
        endcase
        if (state_reg == S_POP && !fin_reg && ph_reg)
        begin
            case (opc_reg)
                CH_PLUS:  r_next = r_next + b_reg;
                CH_MINUS: r_next = r_next - b_reg;
                CH_DIV:
                begin
                    if (b_reg == '0)
                    begin
                        r_next = '0;
                        if (stat_next == ST_OK)
                            stat_next = ST_DIVZ;
                    end
                    else
                        div_start = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            pend_reg  <= 1'b0;
            skip_reg  <= 1'b0;
            stat_reg  <= ST_OK;
            fin_reg   <= 1'b0;
            ph_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            skip_reg  <= skip_next;
            stat_reg  <= stat_next;
            fin_reg   <= fin_next;
            ph_reg    <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        opc_reg <= opc_next;
        val_reg <= val_next;
        ost_reg <= ost_next;
    end

    assign out_valid = (state_reg == S_OUT);
    assign value     = val_reg;
    assign status    = ost_reg;

endmodule

// File: tb/postfix_expression_evaluator_top_test.sv
// Testbench for the postfix expression evaluator: drives characters and end marks,
// predicts value and status per expression, and checks each result in order.
// Depends on pee_pkg and postfix_expression_evaluator_top.
module postfix_expression_evaluator_top_test
    import pee_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoe;
    } char_req_t;

    typedef struct packed {
        logic [31:0] val;
        status_t     st;
    } answer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [7:0] char_byte;
    logic end_of_expr;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] value;
    logic [1:0] status;

    char_req_t pending_chars[$];
    answer_t   expected_answers[$];

    logic [31:0] eval_stack[DEPTH];
    int          eval_count;
    logic [31:0] eval_acc;
    bit          eval_pending;
    bit          eval_skip;
    status_t     eval_status;

    int  errors;
    int  answers_seen;
    int  cycles;
    int  idle_pct;
    bit  drain_done;
    bit  hold_send;
    int  status_hits[4];

    postfix_expression_evaluator_top #(.STACK_DEPTH(DEPTH), .VALUE_WIDTH(32)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .char_byte(char_byte), .end_of_expr(end_of_expr),
        .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void note_error(status_t s);
        if (eval_status == ST_OK)
            eval_status = s;
    endfunction

    function automatic void stack_push(logic [31:0] v);
        if (eval_count >= DEPTH)
        begin
            note_error(ST_OVER);
            return;
        end
        eval_stack[eval_count] = v;
        eval_count++;
    endfunction

    function automatic logic [31:0] stack_pop();
        if (eval_count == 0)
        begin
            note_error(ST_UNDER);
            return 32'd0;
        end
        eval_count--;
        return eval_stack[eval_count];
    endfunction

    function automatic logic [31:0] trunc_divide(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        if (b == 32'd0)
        begin
            note_error(ST_DIVZ);
            return 32'd0;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic void eval_clear();
        eval_count = 0;
        eval_acc = 0;
        eval_pending = 0;
        eval_skip = 0;
        eval_status = ST_OK;
    endfunction

    function automatic void eval_char(char_req_t r);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
        answer_t ans;
        if (r.eoe)
        begin
            if (eval_pending)
                stack_push(eval_acc);
            ans.val = stack_pop();
            ans.st = eval_status;
            expected_answers.push_back(ans);
            eval_clear();
            return;
        end
        if (eval_skip)
        begin
            eval_skip = 0;
            return;
        end
        if (r.ch == CH_SPACE)
        begin
            if (eval_pending)
            begin
                stack_push(eval_acc);
                eval_acc = 0;
                eval_pending = 0;
            end
            return;
        end
        if (!eval_pending && (r.ch == CH_PLUS || r.ch == CH_MINUS ||
                              r.ch == CH_MUL || r.ch == CH_DIV))
        begin
            b = stack_pop();
            a = stack_pop();
            case (r.ch)
                CH_PLUS:  res = a + b;
                CH_MINUS: res = a - b;
                CH_MUL:   res = a * b;
                default:  res = trunc_divide(a, b);
            endcase
            stack_push(res);
            eval_skip = 1;
            return;
        end
        eval_acc = eval_acc * 32'd10 + {24'd0, r.ch} - 32'd48;
        eval_pending = 1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic queue_text(string s, bit with_end);
        char_req_t r;
        foreach (s[i])
        begin
            r.ch = s[i];
            r.eoe = 0;
            pending_chars.push_back(r);
        end
        if (with_end)
        begin
            r.ch = 8'($urandom);
            r.eoe = 1;
            pending_chars.push_back(r);
        end
    endtask

    function automatic string random_number();
        string s;
        int n;
        s = "";
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
            s = {s, string'(8'($urandom_range(48, 57)))};
        return s;
    endfunction

    function automatic string random_expression();
        string s;
        string ops;
        int depth;
        int steps;
        bit noisy;
        ops = "+-*/";
        s = "";
        depth = 0;
        noisy = ($urandom_range(0, 9) < 2);
        steps = $urandom_range(1, 12);
        for (int i = 0; i < steps; i++)
        begin
            if (noisy && $urandom_range(0, 3) == 0)
                s = {s, string'(8'($urandom))};
            else if (depth >= 2 && ($urandom_range(0, 1) == 0 || depth > 14))
            begin
                s = {s, string'(ops[$urandom_range(0, 3)]), " "};
                depth--;
            end
            else
            begin
                s = {s, random_number(), " "};
                depth++;
            end
        end
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            char_byte <= 8'd0;
            end_of_expr <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_chars.size() > 0 && !hold_send &&
                $urandom_range(0, 99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                char_byte <= pending_chars[0].ch;
                end_of_expr <= pending_chars[0].eoe;
                eval_char(pending_chars.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= idle_pct);
            if (out_valid && out_ready)
            begin
                answers_seen++;
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected result", value, 32'd0);
                else
                begin
                    if (value !== expected_answers[0].val)
                        report_mismatch("value", value, expected_answers[0].val);
                    if (status !== expected_answers[0].st)
                        report_mismatch("status", {30'd0, status},
                                        {30'd0, expected_answers[0].st});
                    status_hits[expected_answers[0].st]++;
                    void'(expected_answers.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        answers_seen = 0;
        cycles = 0;
        idle_pct = 29;
        drain_done = 0;
        hold_send = 0;
        eval_clear();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        queue_text("3 4 + ", 1);
        queue_text("9 5 - ", 1);
        queue_text("6 7 * ", 1);
        queue_text("7 0 2 - / ", 1);
        queue_text("2147483648 1 - 0 1 - / ", 1);
        queue_text("5 0 / ", 1);
        queue_text("+ ", 1);
        queue_text("", 1);
        queue_text("  12", 1);
        queue_text("1 2 3 4 5 6 7 8 9 10 11 12 13 14 15 16 17 ", 1);
        queue_text("4294967295 9999999999 + ", 1);
        queue_text({"1 2 +", 8'hFF, "3 -x"}, 1);
        queue_text({8'h00, 8'h7F, 8'h80, " 1+2 "}, 1);

        while (pending_chars.size() > 0 || expected_answers.size() > 0)
            @(posedge clk);

        for (int n = 0; n < 720; )
        begin
            string e;
            e = random_expression();
            queue_text(e, 1);
            n += e.len() + 1;
            if (n >= 250 && n < 500)
                idle_pct = 0;
            else
                idle_pct = 29;
            while (pending_chars.size() > 20)
                @(posedge clk);
            if (n >= 550 && !drain_done)
            begin
                drain_done = 1;
                hold_send = 1;
                while (expected_answers.size() > 0)
                    @(posedge clk);
                hold_send = 0;
            end
        end

        while (pending_chars.size() > 0 || expected_answers.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_answers.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("expressions checked: %0d; status ok/under/over/divz: %0d/%0d/%0d/%0d",
                 answers_seen, status_hits[0], status_hits[1], status_hits[2],
                 status_hits[3]);
        if (errors == 0 && expected_answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
